>>> sv/tset_pkg.sv
`timescale 1ns / 1ps

package tset_pkg;

	// Fixed field widths of the item channels
	localparam int CMD_BITS     = 2;
	localparam int HOUR_BITS    = 5;
	localparam int MINUTE_BITS  = 6;
	localparam int PORT_PAYLOAD = 32;
	localparam int INDEX_BITS   = 6;
	localparam int STATUS_BITS  = 2;
	localparam int TOTAL_BITS   = 7;

	// Command codes
	localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd2;

	// Status codes
	localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_BAD_IDX = 2'd2;

	typedef struct packed {
		logic [CMD_BITS-1:0]     command;
		logic [HOUR_BITS-1:0]    event_hour;
		logic [MINUTE_BITS-1:0]  event_minute;
		logic [PORT_PAYLOAD-1:0] event_payload;
		logic [INDEX_BITS-1:0]   entry_index;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_BITS-1:0]  status;
		logic [INDEX_BITS-1:0]   position;
		logic [HOUR_BITS-1:0]    out_hour;
		logic [MINUTE_BITS-1:0]  out_minute;
		logic [PORT_PAYLOAD-1:0] out_payload;
		logic [TOTAL_BITS-1:0]   entry_total;
	} out_item_t;

	// Pointer moves
	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_DEC,
		PTR_INC
	} ptr_op_t;

	// Table writes
	typedef enum logic [2:0] {
		WR_NONE,
		WR_SHIFT_UP,
		WR_SHIFT_DOWN,
		WR_NEW_ABOVE,
		WR_NEW_ZERO
	} wr_op_t;

	// Result updates
	typedef enum logic [2:0] {
		RES_HOLD,
		RES_ZERO,
		RES_FULL,
		RES_BAD,
		RES_ENTRY,
		RES_POS_ABOVE,
		RES_POS_ZERO
	} res_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic    load;
		ptr_op_t ptr_op;
		wr_op_t  wr_op;
		res_op_t res_op;
		cnt_op_t cnt_op;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_BITS-1:0] command;
		logic                full;
		logic                empty;
		logic                idx_bad;
		logic                del_last;
		logic                gt;
		logic                at_zero;
		logic                at_last;
	} dp_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INS_SCAN,
		ST_INS_LAST,
		ST_RD_WAIT,
		ST_DEL_CAP,
		ST_DEL_SHIFT,
		ST_DONE
	} state_t;

endpackage

>>> sv/time_sorted_event_table_unit.sv
`timescale 1ns / 1ps

// Channel  Signals                          Direction  Accepted when
// cmd      cmd_valid, cmd_stall, cmd_item   into block cmd_valid && !cmd_stall
// rsp      rsp_valid, rsp_stall, rsp_item   out of     rsp_valid && !rsp_stall
//
// One item at a time. Read: decode, RAM wait, result. Insert: decode, one RAM
// step per held entry later than the new one, then the write. Delete: decode,
// capture, a step per entry above the index. Rejected/unused: decode, result.
// Reset clears entry count, state, rsp_valid; memory needs no clearing pass.
// A result waits in the output register under rsp_stall; the next item can
// be taken meanwhile and its result is held back until that register frees.

module time_sorted_event_table_unit #(
	parameter int TABLE_DEPTH  = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  tset_pkg::in_item_t  cmd_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output tset_pkg::out_item_t rsp_item
);
	import tset_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	tset_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	tset_datapath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_item (cmd_item),
		.dp_cmd   (dp_cmd),
		.dp_stat  (dp_stat),
		.rsp_item (rsp_item)
	);

endmodule

>>> sv/tset_ram.sv
`timescale 1ns / 1ps

module tset_ram #(
	parameter int WIDTH = 43,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/tset_datapath.sv
`timescale 1ns / 1ps

module tset_datapath #(
	parameter int TABLE_DEPTH  = 64,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tset_pkg::in_item_t cmd_item,
	input  tset_pkg::dp_cmd_t  dp_cmd,
	output tset_pkg::dp_stat_t dp_stat,
	output tset_pkg::out_item_t rsp_item
);
	import tset_pkg::*;

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int CW    = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW  = (CW > INDEX_BITS) ? CW : INDEX_BITS;
	localparam int TIMEW = HOUR_BITS + MINUTE_BITS;
	localparam int EW    = TIMEW + PAYLOAD_BITS;
	localparam int PWIDE = (PAYLOAD_BITS > PORT_PAYLOAD) ? PAYLOAD_BITS : PORT_PAYLOAD;

	in_item_t        item_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   ptr_q;
	logic [AW-1:0]   addr_q;
	out_item_t       wres_q;
	out_item_t       wres_d;
	out_item_t       out_q;
	out_item_t       out_d;

	logic [EW-1:0]           rd_data;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [EW-1:0]           wr_data;
	logic [EW-1:0]           new_entry;
	logic [PWIDE-1:0]        pay_in_wide;
	logic [PWIDE-1:0]        pay_out_wide;
	logic [HOUR_BITS-1:0]    r_hour;
	logic [MINUTE_BITS-1:0]  r_minute;
	logic [PAYLOAD_BITS-1:0] r_payload;
	logic [CMPW-1:0]         idx_w;
	logic [CMPW-1:0]         cnt_w;
	logic [AW-1:0]           addr_above;
	logic [AW-1:0]           addr_below;

	// Entry layout: hour, minute, payload
	assign pay_in_wide  = PWIDE'(item_q.event_payload);
	assign new_entry    = {item_q.event_hour, item_q.event_minute,
		pay_in_wide[PAYLOAD_BITS-1:0]};
	assign r_hour       = rd_data[EW-1 -: HOUR_BITS];
	assign r_minute     = rd_data[PAYLOAD_BITS +: MINUTE_BITS];
	assign r_payload    = rd_data[PAYLOAD_BITS-1:0];
	assign pay_out_wide = PWIDE'(r_payload);

	assign addr_above = addr_q + AW'(1);
	assign addr_below = addr_q - AW'(1);

	// Status towards the controller
	assign idx_w = CMPW'(item_q.entry_index);
	assign cnt_w = CMPW'(count_q);
	always_comb begin
		dp_stat.command  = item_q.command;
		dp_stat.full     = (count_q == CW'(TABLE_DEPTH));
		dp_stat.empty    = (count_q == '0);
		dp_stat.idx_bad  = (idx_w >= cnt_w);
		dp_stat.del_last = ((idx_w + CMPW'(1)) == cnt_w);
		dp_stat.gt       = ({r_hour, r_minute} > {item_q.event_hour, item_q.event_minute});
		dp_stat.at_zero  = (addr_q == '0);
		dp_stat.at_last  = ((CW'(addr_q) + CW'(1)) == count_q);
	end

	// Table write select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = rd_data;
		case (dp_cmd.wr_op)
			WR_SHIFT_UP: begin
				wr_en   = 1'b1;
				wr_addr = addr_above;
			end
			WR_SHIFT_DOWN: begin
				wr_en   = 1'b1;
				wr_addr = addr_below;
			end
			WR_NEW_ABOVE: begin
				wr_en   = 1'b1;
				wr_addr = addr_above;
				wr_data = new_entry;
			end
			WR_NEW_ZERO: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = new_entry;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	tset_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (dp_cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Captured item, read pointer and the address of the data now at the RAM output
	always_ff @(posedge clk) begin
		addr_q <= ptr_q;
		if (dp_cmd.load) begin
			item_q <= cmd_item;
			if (cmd_item.command == CMD_INSERT) begin
				ptr_q <= AW'(count_q - CW'(1));
			end else begin
				ptr_q <= AW'(cmd_item.entry_index);
			end
		end else begin
			case (dp_cmd.ptr_op)
				PTR_DEC: ptr_q <= ptr_q - AW'(1);
				PTR_INC: ptr_q <= ptr_q + AW'(1);
				default: ptr_q <= ptr_q;
			endcase
		end
	end

	// Working result, next value
	always_comb begin
		wres_d = wres_q;
		case (dp_cmd.res_op)
			RES_ZERO: begin
				wres_d        = '0;
				wres_d.status = STATUS_DONE;
			end
			RES_FULL: begin
				wres_d        = '0;
				wres_d.status = STATUS_FULL;
			end
			RES_BAD: begin
				wres_d          = '0;
				wres_d.status   = STATUS_BAD_IDX;
				wres_d.position = item_q.entry_index;
			end
			RES_ENTRY: begin
				wres_d.status      = STATUS_DONE;
				wres_d.position    = item_q.entry_index;
				wres_d.out_hour    = r_hour;
				wres_d.out_minute  = r_minute;
				wres_d.out_payload = pay_out_wide[PORT_PAYLOAD-1:0];
				wres_d.entry_total = '0;
			end
			RES_POS_ABOVE: begin
				wres_d          = '0;
				wres_d.status   = STATUS_DONE;
				wres_d.position = INDEX_BITS'(addr_above);
			end
			RES_POS_ZERO: begin
				wres_d        = '0;
				wres_d.status = STATUS_DONE;
			end
			default: begin
				wres_d = wres_q;
			end
		endcase
	end

	// Working result
	always_ff @(posedge clk) begin
		wres_q <= wres_d;
	end

	// Output register, count taken after the operation has settled
	always_comb begin
		out_d             = wres_q;
		out_d.entry_total = TOTAL_BITS'(count_q);
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_item = out_q;

endmodule

>>> sv/tset_ctrl.sv
`timescale 1ns / 1ps

module tset_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	input  tset_pkg::dp_stat_t dp_stat,
	output tset_pkg::dp_cmd_t  dp_cmd
);
	import tset_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dp_cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d         = state_q;
		dp_cmd          = '0;
		dp_cmd.ptr_op   = PTR_HOLD;
		dp_cmd.wr_op    = WR_NONE;
		dp_cmd.res_op   = RES_HOLD;
		dp_cmd.cnt_op   = CNT_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					dp_cmd.load = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (dp_stat.command == CMD_INSERT) begin
					if (dp_stat.full) begin
						dp_cmd.res_op = RES_FULL;
						state_d       = ST_DONE;
					end else if (dp_stat.empty) begin
						state_d = ST_INS_LAST;
					end else begin
						dp_cmd.ptr_op = PTR_DEC;
						state_d       = ST_INS_SCAN;
					end
				end else if (dp_stat.command == CMD_DELETE ||
					dp_stat.command == CMD_READ) begin
					if (dp_stat.idx_bad) begin
						dp_cmd.res_op = RES_BAD;
						state_d       = ST_DONE;
					end else if (dp_stat.command == CMD_READ) begin
						state_d = ST_RD_WAIT;
					end else begin
						dp_cmd.ptr_op = PTR_INC;
						state_d       = ST_DEL_CAP;
					end
				end else begin
					dp_cmd.res_op = RES_ZERO;
					state_d       = ST_DONE;
				end
			end
			// Walk down from the top, moving later entries up one slot
			ST_INS_SCAN: begin
				if (dp_stat.gt) begin
					dp_cmd.wr_op = WR_SHIFT_UP;
					if (dp_stat.at_zero) begin
						state_d = ST_INS_LAST;
					end else begin
						dp_cmd.ptr_op = PTR_DEC;
					end
				end else begin
					dp_cmd.wr_op  = WR_NEW_ABOVE;
					dp_cmd.res_op = RES_POS_ABOVE;
					dp_cmd.cnt_op = CNT_INC;
					state_d       = ST_DONE;
				end
			end
			ST_INS_LAST: begin
				dp_cmd.wr_op  = WR_NEW_ZERO;
				dp_cmd.res_op = RES_POS_ZERO;
				dp_cmd.cnt_op = CNT_INC;
				state_d       = ST_DONE;
			end
			ST_RD_WAIT: begin
				dp_cmd.res_op = RES_ENTRY;
				state_d       = ST_DONE;
			end
			// Removed entry is at the RAM output
			ST_DEL_CAP: begin
				dp_cmd.res_op = RES_ENTRY;
				if (dp_stat.del_last) begin
					dp_cmd.cnt_op = CNT_DEC;
					state_d       = ST_DONE;
				end else begin
					dp_cmd.ptr_op = PTR_INC;
					state_d       = ST_DEL_SHIFT;
				end
			end
			// Move each following entry down one slot
			ST_DEL_SHIFT: begin
				dp_cmd.wr_op = WR_SHIFT_DOWN;
				if (dp_stat.at_last) begin
					dp_cmd.cnt_op = CNT_DEC;
					state_d       = ST_DONE;
				end else begin
					dp_cmd.ptr_op = PTR_INC;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					dp_cmd.out_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
